### hw/rtl/blp_pkg.sv
// Shared types and constants for the BER length field parser.
`timescale 1ns / 1ps

package blp_pkg;

    // Longest long-form length the parser accepts, in bytes.
    localparam int unsigned MAX_LENGTH_BYTES = 8;
    localparam int unsigned LEFT_W           = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int unsigned LEN_W            = 64;

    // APB register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_FORM_MODE = 1'b0;

    // form_mode codes; the unused code behaves as FORM_ANY
    localparam logic [1:0] FORM_ANY        = 2'd0;
    localparam logic [1:0] FORM_DEFINITE   = 2'd1;
    localparam logic [1:0] FORM_INDEFINITE = 2'd2;

    // First-byte markers
    localparam logic [7:0] BER_LONG_FLAG  = 8'h80;
    localparam logic [7:0] BER_COUNT_MASK = 8'h7f;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_INDEF_FORBIDDEN = 3'd1,
        ST_LONG_FORBIDDEN  = 3'd2,
        ST_SHORT_FORBIDDEN = 3'd3,
        ST_TOO_MANY        = 3'd4,
        ST_TRUNCATED       = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } t_in_beat;

    typedef struct packed {
        logic [LEN_W-1:0] length_value;
        logic             is_indefinite;
        logic [2:0]       status;
    } t_out_beat;

    // Decoder to output buffer
    typedef struct packed {
        logic      emit;
        t_out_beat beat;
    } t_dec_result;

endpackage

### hw/rtl/blp_apb_regs.sv
// APB register block holding form_mode.
`timescale 1ns / 1ps

module blp_apb_regs
    import blp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [1:0]            o_form_mode
);

    logic [1:0] r_form_mode;
    logic [1:0] n_form_mode;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        n_form_mode = r_form_mode;
        if (wr_en && reg_idx == REG_FORM_MODE) begin
            n_form_mode = pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_FORM_MODE: prdata = {{(APB_DATA_W-2){1'b0}}, r_form_mode};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form_mode <= FORM_ANY;
        end else begin
            r_form_mode <= n_form_mode;
        end
    end

    assign o_form_mode = r_form_mode;

endmodule

### hw/rtl/blp_field_decoder.sv
// Length field state and combinational decode of one byte.
`timescale 1ns / 1ps

module blp_field_decoder
    import blp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_beat    i_beat,
    input  logic [1:0]  i_form_mode,
    output t_dec_result o_result
);

    logic              r_collecting;
    logic              n_collecting;
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;
    logic [LEN_W-1:0]  r_acc;
    logic [LEN_W-1:0]  n_acc;

    logic [LEN_W-1:0]  shifted;
    logic [LEFT_W-1:0] left_dec;
    logic [6:0]        cnt;
    t_dec_result       res;

    assign shifted  = {r_acc[LEN_W-9:0], i_beat.in_byte};
    assign left_dec = r_left - LEFT_W'(1);
    assign cnt      = 7'(i_beat.in_byte & BER_COUNT_MASK);

    always_comb begin
        n_collecting = r_collecting;
        n_left       = r_left;
        n_acc        = r_acc;
        res.emit               = 1'b0;
        res.beat.length_value  = '0;
        res.beat.is_indefinite = 1'b0;
        res.beat.status        = ST_OK;
        if (i_accept) begin
            if (r_collecting) begin
                n_acc  = shifted;
                n_left = left_dec;
                if (left_dec == '0) begin
                    res.emit              = 1'b1;
                    res.beat.length_value = shifted;
                    n_collecting          = 1'b0;
                    n_acc                 = '0;
                end else if (i_beat.buffer_end) begin
                    res.emit        = 1'b1;
                    res.beat.status = ST_TRUNCATED;
                    n_collecting    = 1'b0;
                    n_left          = '0;
                    n_acc           = '0;
                end
            end else if ((i_beat.in_byte & BER_LONG_FLAG) == 8'h00) begin
                // short form
                res.emit = 1'b1;
                if (i_form_mode == FORM_INDEFINITE) begin
                    res.beat.status = ST_SHORT_FORBIDDEN;
                end else begin
                    res.beat.length_value = LEN_W'(i_beat.in_byte);
                end
            end else if (cnt == 7'd0) begin
                // indefinite form
                res.emit = 1'b1;
                if (i_form_mode == FORM_DEFINITE) begin
                    res.beat.status = ST_INDEF_FORBIDDEN;
                end else begin
                    res.beat.is_indefinite = 1'b1;
                end
            end else if (i_form_mode == FORM_INDEFINITE) begin
                res.emit        = 1'b1;
                res.beat.status = ST_LONG_FORBIDDEN;
            end else if (cnt > 7'(MAX_LENGTH_BYTES)) begin
                res.emit        = 1'b1;
                res.beat.status = ST_TOO_MANY;
            end else if (i_beat.buffer_end) begin
                res.emit        = 1'b1;
                res.beat.status = ST_TRUNCATED;
            end else begin
                n_collecting = 1'b1;
                n_left       = LEFT_W'(cnt);
                n_acc        = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_left       <= '0;
            r_acc        <= '0;
        end else begin
            r_collecting <= n_collecting;
            r_left       <= n_left;
            r_acc        <= n_acc;
        end
    end

    assign o_result = res;

    // Counter stays within the announced range while collecting.
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_left != '0 && r_left <= LEFT_W'(MAX_LENGTH_BYTES)))
        else $error("length byte counter out of range");

    // Idle parser holds a clean accumulator and counter.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_collecting |-> (r_acc == '0 && r_left == '0))
        else $error("stale accumulator while awaiting first byte");

    // A byte in the collecting phase either finishes the field or leaves it open.
    a_collect_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_collecting && i_accept && !res.emit) |=> r_collecting)
        else $error("field dropped without a result");

endmodule

### hw/rtl/blp_out_skid.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module blp_out_skid
    import blp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dec_result i_result,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_beat   o_out_data,
    output logic        o_full
);

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_beat r_skid;
    t_out_beat n_skid;
    logic      pop;

    assign pop = r_out_valid & ~i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_result.emit;
                n_skid       = i_result.beat;
            end else begin
                n_out_valid = i_result.emit;
                n_out       = i_result.beat;
            end
        end else if (i_result.emit) begin
            n_skid_valid = 1'b1;
            n_skid       = i_result.beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_full      = r_skid_valid;

    // Skid only fills behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat with the output register empty");

    // Full buffer must not take a new result unless a beat leaves.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_result.emit) |-> pop)
        else $error("result pushed into a full buffer");

    // Skid content moves forward when the output beat is taken.
    a_skid_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_out_valid && r_out == $past(r_skid)))
        else $error("skid beat lost on drain");

endmodule

### hw/rtl/ber_length_field_parser.sv
// Top level of the BER length field parser.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Payload
// --------  ---  ---------------------------  -------------------------------
// in        in   i_in_valid / o_in_stall      i_in_data  (t_in_beat)
// out       out  o_out_valid / i_out_stall    o_out_data (t_out_beat)
// config    in   APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One input beat per cycle while o_in_stall is low; each byte is decoded in
// the cycle it is accepted, together with the accumulator shift and counter
// update, and a result, when the field completes or fails, is registered in
// the output buffer. Reset is synchronous, active low; it clears the parser
// to await a first byte and sets form_mode to "any form". No clearing pass.
// A two-entry output buffer keeps input flowing while a result waits; o_in_stall
// rises only when both entries are occupied.

module ber_length_field_parser
    import blp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input bytes
    input  logic                  i_in_valid,
    input  t_in_beat              i_in_data,
    output logic                  o_in_stall,
    // results
    output logic                  o_out_valid,
    output t_out_beat             o_out_data,
    input  logic                  i_out_stall
);

    logic [1:0]  form_mode_q;
    logic        in_accept;
    logic        buf_full;
    t_dec_result dec_result;

    // form_mode is sampled only on a first byte inside the decoder
    blp_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_form_mode (form_mode_q)
    );

    // stall only when the skid entry is taken
    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid & ~buf_full;

    blp_field_decoder u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_beat      (i_in_data),
        .i_form_mode (form_mode_q),
        .o_result    (dec_result)
    );

    blp_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (dec_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_full      (buf_full)
    );

endmodule
